>>> rtl/twspc_pkg.sv
// ----------------------------------------------------------------------------
// twspc_pkg
// Shared types and constants for the two-wheel speed PID controller.
// ----------------------------------------------------------------------------
package twspc_pkg;

    localparam int STEER_TABLE_DEPTH_DEF = 45;
    localparam int SPLIT_TABLE_LEN       = 45;
    localparam int CNT_W    = 15;
    localparam int SERVO_W  = 16;
    localparam int GAIN_W   = 8;
    localparam int DRIVE_W  = 14;
    localparam int ERR_W    = 18;
    localparam int COEF_W   = 20;
    localparam int PROD_W   = ERR_W + COEF_W;
    localparam int SUM_W    = 40;
    localparam int ENTRY_W  = 17;
    localparam int SPLIT_W  = 13;
    localparam int TGT_W    = 14;
    localparam int IDX_W    = 6;
    localparam int PADDR_W  = 5;

    localparam logic [DRIVE_W-1:0] ACC_MAX = 14'd8800;
    localparam logic [DRIVE_W-1:0] ACC_MIN = 14'd10;

    // APB register indexes
    localparam logic [2:0] REG_CENTER      = 3'd0;
    localparam logic [2:0] REG_LEFT_LIMIT  = 3'd1;
    localparam logic [2:0] REG_RIGHT_LIMIT = 3'd2;
    localparam logic [2:0] REG_LEFT_GAIN   = 3'd3;
    localparam logic [2:0] REG_RIGHT_GAIN  = 3'd4;

    // Q16 split table
    localparam logic [ENTRY_W-1:0] SPLIT_TABLE [SPLIT_TABLE_LEN] = '{
        17'd0,      17'd66446,  17'd67364,  17'd68281,  17'd69199,  17'd70123,
        17'd71041,  17'd71965,  17'd72902,  17'd73832,  17'd74776,  17'd75720,
        17'd76677,  17'd77633,  17'd78603,  17'd79580,  17'd80563,  17'd81559,
        17'd82568,  17'd83584,  17'd84613,  17'd85655,  17'd86717,  17'd87785,
        17'd88873,  17'd89980,  17'd92248,  17'd93408,  17'd94594,  17'd95800,
        17'd97032,  17'd98290,  17'd99581,  17'd100899, 17'd102242, 17'd103625,
        17'd105041, 17'd106489, 17'd107983, 17'd109523, 17'd111103, 17'd112741,
        17'd114425, 17'd116156, 17'd117964
    };

    // Incremental PID weights on e0, e1, e2 (Q16): 1.2+0.08+2, -(0.08+4), 2
    localparam logic signed [COEF_W-1:0] COEF_E0 = 20'sd214957;
    localparam logic signed [COEF_W-1:0] COEF_E1 = -20'sd267386;
    localparam logic signed [COEF_W-1:0] COEF_E2 = 20'sd131072;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SPLIT, S_ERR, S_MUL, S_UPD, S_FIN, S_OUT
    } t_state;

    function automatic logic signed [COEF_W-1:0] pid_coef(input logic [1:0] term);
        logic signed [COEF_W-1:0] c;
        case (term)
            2'd0:    c = COEF_E0;
            2'd1:    c = COEF_E1;
            2'd2:    c = COEF_E2;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/twspc_in_if.sv
// ----------------------------------------------------------------------------
// twspc_in_if
// Control tick channel: encoder counts, servo command and mode flags.
// ----------------------------------------------------------------------------
interface twspc_in_if;
    logic        valid;
    logic        ready;
    logic [14:0] left_count;
    logic [14:0] right_count;
    logic [15:0] steer_command;
    logic        corner_mode;
    logic        corner_right;
    logic        corner_left;
    logic        stop_request;

    modport source (output valid, left_count, right_count, steer_command,
                    corner_mode, corner_right, corner_left, stop_request,
                    input ready);
    modport sink   (input valid, left_count, right_count, steer_command,
                    corner_mode, corner_right, corner_left, stop_request,
                    output ready);
endinterface

>>> rtl/twspc_out_if.sv
// ----------------------------------------------------------------------------
// twspc_out_if
// Drive result channel: left and right motor duties.
// ----------------------------------------------------------------------------
interface twspc_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] left_drive;
    logic [13:0] right_drive;

    modport source (output valid, left_drive, right_drive, input ready);
    modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

>>> rtl/two_wheel_speed_pid_control.sv
// ----------------------------------------------------------------------------
// two_wheel_speed_pid_control
// Speed target selection, steering split and two incremental PIDs on one
// shared multiplier and a bit-serial divider, under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | transaction
//  i_in     | in  | valid/ready      | one control tick (counts, servo, flags)
//  o_out    | out | valid/ready      | left/right drive duty
//  APB      | in  | psel/penable     | register write/read, pready tied high
//
//  Steps: a tick runs accept, D divider steps, split, 2 x 5 PID steps, then
//  finish and output, D = bits of STEER_TABLE_DEPTH*65535 (22 at the
//  default). Divider skipped when no split applies; straight wheels go
//  straight to finish.
//  Reset: synchronous, active low; registers to defaults, PID state zero.
//  Stalls: i_in.ready is low from accept until the result transaction leaves.
// ----------------------------------------------------------------------------
module two_wheel_speed_pid_control
    import twspc_pkg::*;
#(
    parameter int STEER_TABLE_DEPTH = STEER_TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    twspc_in_if.sink            i_in,
    twspc_out_if.source         o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Divider width follows the table depth
    localparam int DIVW  = $clog2(STEER_TABLE_DEPTH * 65535 + 1);
    localparam int DCW   = $clog2(DIVW + 1);

    // ---------------- configuration registers ----------------
    logic [SERVO_W-1:0] r_center, r_left_limit, r_right_limit;
    logic [GAIN_W-1:0]  r_left_gain, r_right_gain;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center      <= 16'd1320;
            r_left_limit  <= 16'd1530;
            r_right_limit <= 16'd1110;
            r_left_gain   <= 8'd9;
            r_right_gain  <= 8'd9;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_CENTER:      r_center      <= pwdata[15:0];
                REG_LEFT_LIMIT:  r_left_limit  <= pwdata[15:0];
                REG_RIGHT_LIMIT: r_right_limit <= pwdata[15:0];
                REG_LEFT_GAIN:   r_left_gain   <= pwdata[7:0];
                REG_RIGHT_GAIN:  r_right_gain  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_CENTER:      prdata = {16'd0, r_center};
            REG_LEFT_LIMIT:  prdata = {16'd0, r_left_limit};
            REG_RIGHT_LIMIT: prdata = {16'd0, r_right_limit};
            REG_LEFT_GAIN:   prdata = {24'd0, r_left_gain};
            REG_RIGHT_GAIN:  prdata = {24'd0, r_right_gain};
            default:         prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    t_state r_state, n_state;
    logic   in_acc;

    // Tick latched at accept
    logic [CNT_W-1:0]    r_lc, r_rc;
    logic                r_corner, r_cright, r_cleft, r_stop;
    logic                r_pos;          // angle > 0
    logic signed [16:0]  r_angle;

    // Accept-time decode on the live input
    logic signed [16:0]  a_angle, a_span;
    logic [15:0]         a_mag;
    logic                a_upd, a_div;

    assign a_angle = $signed({1'b0, i_in.steer_command}) - $signed({1'b0, r_center});
    assign a_mag   = a_angle[16] ? 16'(-a_angle) : a_angle[15:0];
    assign a_span  = a_angle[16]
                   ? $signed({1'b0, r_center}) - $signed({1'b0, r_right_limit})
                   : $signed({1'b0, r_left_limit}) - $signed({1'b0, r_center});
    // angle zero outside corner mode: PIDs frozen
    assign a_upd   = i_in.corner_mode || (a_angle != '0);
    assign a_div   = !i_in.corner_mode && (a_angle != '0) && (a_span > 0);

    // Divider
    logic [DIVW-1:0] r_quo;
    logic [15:0]     r_rem, r_den;
    logic [DCW-1:0]  r_dcnt;
    logic [16:0]     d_trial;
    logic            d_ge;

    assign d_trial = {r_rem, r_quo[DIVW-1]};
    assign d_ge    = d_trial >= {1'b0, r_den};

    // PID working state
    logic                    r_wheel;
    logic [1:0]              r_term;
    logic [SPLIT_W-1:0]      r_sp;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [ERR_W-1:0] r_hist [2][3];
    logic [DRIVE_W-1:0]      r_acc  [2];
    logic [DRIVE_W-1:0]      r_hold [2];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) begin
                         n_state = !a_upd ? S_FIN : (a_div ? S_DIV : S_SPLIT);
                     end
            S_DIV:   if (r_dcnt == DCW'(DIVW - 1)) n_state = S_SPLIT;
            S_SPLIT: n_state = S_ERR;
            S_ERR:   n_state = S_MUL;
            S_MUL:   if (r_term == 2'd2) n_state = S_UPD;
            S_UPD:   n_state = r_wheel ? S_FIN : S_ERR;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        o_out.valid = (r_state == S_OUT);
    end

    assign in_acc = i_in.valid && i_in.ready;
    assign o_out.left_drive  = r_hold[0];
    assign o_out.right_drive = r_hold[1];

    // ---------------- table index and split ----------------
    logic [DIVW-1:0]    q_m1;
    logic               idx_ok;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] entry;
    logic [11:0]        gain10;

    assign q_m1   = r_quo - DIVW'(1);
    // quotient zero, or index past the depth or the table: no split
    assign idx_ok = (r_quo != '0) && (q_m1 < DIVW'(STEER_TABLE_DEPTH))
                 && (q_m1 < DIVW'(SPLIT_TABLE_LEN));
    assign idx    = idx_ok ? q_m1[IDX_W-1:0] : '0;
    assign entry  = SPLIT_TABLE[idx];
    assign gain10 = (r_pos ? {4'd0, r_left_gain} : {4'd0, r_right_gain}) * 12'd10;

    // ---------------- targets ----------------
    logic [9:0]              base;
    logic                    mid40, mid20, over40, over60;
    logic                    l_lt100, r_lt100, any_gt300, any_gt250, any_lt200;
    logic signed [TGT_W-1:0] tgt_l, tgt_r, tgt, sp_s, sp_h;

    assign mid20  = (r_angle > -17'sd20) && (r_angle < 17'sd20);
    assign mid40  = (r_angle > -17'sd40) && (r_angle < 17'sd40);
    assign over40 = (r_angle > 17'sd40) || (r_angle < -17'sd40);
    assign over60 = (r_angle > 17'sd60) || (r_angle < -17'sd60);
    assign l_lt100   = r_lc < 15'd100;
    assign r_lt100   = r_rc < 15'd100;
    assign any_gt300 = (r_lc > 15'd300) || (r_rc > 15'd300);
    assign any_gt250 = (r_lc > 15'd250) || (r_rc > 15'd250);
    assign any_lt200 = (r_lc < 15'd200) || (r_rc < 15'd200);

    always_comb begin
        if (l_lt100 && r_lt100 && mid20)  base = 10'd600;
        else if (any_gt300 && mid40)      base = 10'd320;
        else if (any_gt250 && over40)     base = 10'd150;
        else if (any_lt200 && mid40)      base = 10'd300;
        else if (any_lt200 && over60)     base = 10'd200;
        else                              base = 10'd230;
    end

    assign sp_s = $signed({1'b0, r_sp});
    assign sp_h = $signed({2'b0, r_sp[SPLIT_W-1:1]});

    always_comb begin
        if (r_corner) begin
            if (r_cright) begin
                tgt_l = 14'sd300;  tgt_r = -14'sd100;
            end else if (r_cleft) begin
                tgt_l = -14'sd100; tgt_r = 14'sd300;
            end else begin
                tgt_l = 14'sd230;  tgt_r = 14'sd230;
            end
        end else if (r_pos) begin
            tgt_l = $signed({4'd0, base}) - sp_h;
            tgt_r = $signed({4'd0, base}) + sp_s;
        end else begin
            tgt_l = $signed({4'd0, base}) + sp_s;
            tgt_r = $signed({4'd0, base}) - sp_h;
        end
    end

    assign tgt = r_wheel ? tgt_r : tgt_l;

    // ---------------- shared multiplier ----------------
    logic signed [ERR_W-1:0]  mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    always_comb begin
        if (r_state == S_SPLIT) begin
            mul_a = $signed({1'b0, entry});
            mul_b = $signed({8'd0, gain10});
        end else begin
            mul_a = r_hist[r_wheel][r_term];
            mul_b = pid_coef(r_term);
        end
    end

    assign prod = mul_a * mul_b;

    // ---------------- error and accumulator update ----------------
    logic signed [ERR_W-1:0] err;
    logic signed [23:0]      inc;
    logic signed [24:0]      acc_sum;
    logic [DRIVE_W-1:0]      acc_new;

    assign err = ERR_W'(tgt) - $signed({3'b0, r_wheel ? r_rc : r_lc});
    // divide by 65536, truncated toward zero
    assign inc = r_sum[SUM_W-1:16]
               + ((r_sum[SUM_W-1] && (r_sum[15:0] != '0)) ? 24'sd1 : 24'sd0);
    assign acc_sum = $signed({11'd0, r_acc[r_wheel]}) + 25'(inc);

    always_comb begin
        if (acc_sum >= $signed({11'd0, ACC_MAX}))     acc_new = ACC_MAX;
        else if (acc_sum < $signed({11'd0, ACC_MIN})) acc_new = ACC_MIN;
        else                                          acc_new = acc_sum[DRIVE_W-1:0];
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dcnt  <= '0;
            r_term  <= '0;
            r_wheel <= 1'b0;
            for (int w = 0; w < 2; w++) begin
                r_acc[w]  <= '0;
                r_hold[w] <= '0;
                for (int k = 0; k < 3; k++) r_hist[w][k] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (in_acc) begin
                    r_lc     <= i_in.left_count;
                    r_rc     <= i_in.right_count;
                    r_corner <= i_in.corner_mode;
                    r_cright <= i_in.corner_right;
                    r_cleft  <= i_in.corner_left;
                    r_stop   <= i_in.stop_request;
                    r_angle  <= a_angle;
                    r_pos    <= !a_angle[16] && (a_angle != '0);
                    r_quo    <= a_div ? DIVW'(STEER_TABLE_DEPTH) * DIVW'(a_mag) : '0;
                    r_den    <= a_span[15:0];
                    r_rem    <= '0;
                    r_dcnt   <= '0;
                    r_wheel  <= 1'b0;
                end
                S_DIV: begin
                    r_rem  <= d_ge ? 16'(d_trial - {1'b0, r_den}) : d_trial[15:0];
                    r_quo  <= {r_quo[DIVW-2:0], d_ge};
                    r_dcnt <= r_dcnt + DCW'(1);
                end
                S_SPLIT: r_sp <= prod[SPLIT_W+15:16];
                S_ERR: begin
                    r_hist[r_wheel][2] <= r_hist[r_wheel][1];
                    r_hist[r_wheel][1] <= r_hist[r_wheel][0];
                    r_hist[r_wheel][0] <= err;
                    r_sum  <= '0;
                    r_term <= '0;
                end
                S_MUL: begin
                    r_sum  <= r_sum + SUM_W'(prod);
                    r_term <= r_term + 2'd1;
                end
                S_UPD: begin
                    r_acc[r_wheel]  <= acc_new;
                    r_hold[r_wheel] <= acc_new;
                    r_wheel         <= 1'b1;
                end
                S_FIN: if (r_stop) begin
                    r_hold[0] <= '0;
                    r_hold[1] <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/twspc_checker.sv
// ----------------------------------------------------------------------------
// twspc_checker
// Port-level checks for the two-wheel speed PID controller.
// ----------------------------------------------------------------------------
module twspc_checker
    import twspc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [DRIVE_W-1:0] left_drive,
    input logic [DRIVE_W-1:0] right_drive
);

    // one tick in flight: no accept while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input ready while result pending");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (left_drive <= ACC_MAX && right_drive <= ACC_MAX))
        else $error("drive out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(left_drive)
                                       && $stable(right_drive)))
        else $error("result dropped or changed under stall");

endmodule

bind two_wheel_speed_pid_control twspc_checker u_twspc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_in.valid),
    .in_ready    (i_in.ready),
    .out_valid   (o_out.valid),
    .out_ready   (o_out.ready),
    .left_drive  (o_out.left_drive),
    .right_drive (o_out.right_drive)
);
